// ===== design/assert_macros.svh =====
// Assertion macros shared by the integer-to-radix-text RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== design/itr_pkg.sv =====
// Shared types, constants, microcode and helpers for integer_to_radix_text.
// No dependencies; used by itr_sequencer, itr_datapath and the top level.
`default_nettype none

package itr_pkg;

   // Defaults and fixed field widths
   localparam int VALUE_WIDTH_DEF = 64;
   localparam int CHUNK_BITS      = 8;
   localparam int UPC_WIDTH       = 3;

   localparam logic [4:0] RADIX_MIN     = 5'd2;
   localparam logic [4:0] RADIX_MAX     = 5'd16;
   localparam logic [6:0] ASCII_ZERO    = 7'd48;
   localparam logic [6:0] ASCII_UPPER_A = 7'd65;
   localparam logic [6:0] ASCII_NINE    = 7'd57;
   localparam logic [6:0] ASCII_UPPER_F = 7'd70;
   localparam logic [3:0] DIGIT_TEN     = 4'd10;

   // Datapath actions
   typedef enum logic [2:0] {
      ACT_NOP,
      ACT_LOAD,
      ACT_DIV,
      ACT_STORE,
      ACT_PUSH
   } act_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_START,
      COND_CHUNK_MORE,
      COND_QUOT_NZ,
      COND_OUT_BUSY,
      COND_DIGITS_MORE
   } cond_type;

   typedef logic [UPC_WIDTH-1:0] upc_type;

   // Program step addresses
   localparam upc_type STEP_IDLE  = 3'd0;
   localparam upc_type STEP_DIV   = 3'd1;
   localparam upc_type STEP_STORE = 3'd2;
   localparam upc_type STEP_READ  = 3'd3;
   localparam upc_type STEP_PUSH  = 3'd4;
   localparam upc_type STEP_NEXT  = 3'd5;
   localparam upc_type STEP_DONE  = 3'd6;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      upc_type  target;
   } ctrl_word_type;

   // Datapath flags seen by the sequencer
   typedef struct packed {
      logic start;
      logic chunk_more;
      logic quot_nz;
      logic out_busy;
      logic digits_more;
   } status_type;

   // Control store: jump to target when cond holds, else fall through.
   function automatic ctrl_word_type ucode_rom(input upc_type addr);
      ctrl_word_type w;
      case (addr)
         STEP_IDLE:  w = '{act: ACT_LOAD,  cond: COND_NO_START,    target: STEP_IDLE};
         STEP_DIV:   w = '{act: ACT_DIV,   cond: COND_CHUNK_MORE,  target: STEP_DIV};
         STEP_STORE: w = '{act: ACT_STORE, cond: COND_QUOT_NZ,     target: STEP_DIV};
         STEP_READ:  w = '{act: ACT_NOP,   cond: COND_NONE,        target: STEP_IDLE};
         STEP_PUSH:  w = '{act: ACT_PUSH,  cond: COND_OUT_BUSY,    target: STEP_PUSH};
         STEP_NEXT:  w = '{act: ACT_NOP,   cond: COND_DIGITS_MORE, target: STEP_PUSH};
         STEP_DONE:  w = '{act: ACT_NOP,   cond: COND_ALWAYS,      target: STEP_IDLE};
         default:    w = '{act: ACT_NOP,   cond: COND_ALWAYS,      target: STEP_IDLE};
      endcase
      return w;
   endfunction

   // Digit value to upper-case ASCII
   function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
      logic [6:0] c;
      if (d < DIGIT_TEN) begin
         c = ASCII_ZERO + 7'(d);
      end else begin
         c = ASCII_UPPER_A + 7'(d - DIGIT_TEN);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/itr_sequencer.sv =====
// Microprogram sequencer: step counter, control store lookup, jump logic.
// Depends on itr_pkg (control word, status and condition types).
`default_nettype none

module itr_sequencer (
   input  wire                   clock,
   input  wire                   reset,
   input  itr_pkg::status_type   status,
   output itr_pkg::ctrl_word_type ctrl
);

   typedef enum logic [0:0] {
      SEQ_RESET,
      SEQ_RUN
   } seq_state_type;

   localparam itr_pkg::ctrl_word_type CTRL_HOLD = '{act: itr_pkg::ACT_NOP,
                                                    cond: itr_pkg::COND_NONE,
                                                    target: itr_pkg::STEP_IDLE};

   seq_state_type    state_ff;
   itr_pkg::upc_type upc_ff;
   itr_pkg::upc_type upc_in;
   logic             take_jump;

   // Datapath idles until the first step after reset
   assign ctrl = (state_ff == SEQ_RUN) ? itr_pkg::ucode_rom(upc_ff) : CTRL_HOLD;

   // Evaluate the jump condition of the current control word
   always_comb begin
      case (ctrl.cond)
         itr_pkg::COND_NONE:        take_jump = 1'b0;
         itr_pkg::COND_ALWAYS:      take_jump = 1'b1;
         itr_pkg::COND_NO_START:    take_jump = !status.start;
         itr_pkg::COND_CHUNK_MORE:  take_jump = status.chunk_more;
         itr_pkg::COND_QUOT_NZ:     take_jump = status.quot_nz;
         itr_pkg::COND_OUT_BUSY:    take_jump = status.out_busy;
         itr_pkg::COND_DIGITS_MORE: take_jump = status.digits_more;
         default:                   take_jump = 1'b0;
      endcase
      upc_in = take_jump ? ctrl.target : upc_ff + itr_pkg::upc_type'(1);
   end

   // Step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_RESET;
         upc_ff   <= itr_pkg::STEP_IDLE;
      end else begin
         state_ff <= SEQ_RUN;
         upc_ff   <= (state_ff == SEQ_RUN) ? upc_in : itr_pkg::STEP_IDLE;
      end
   end

endmodule

`default_nettype wire

// ===== design/itr_datapath.sv =====
// Datapath: magnitude register, byte-wise divider by the radix, digit store
// and output register. Depends on itr_pkg; driven by itr_sequencer.
`default_nettype none

module itr_datapath #(
   parameter int VALUE_WIDTH = itr_pkg::VALUE_WIDTH_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  itr_pkg::ctrl_word_type ctrl,
   output itr_pkg::status_type    status,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire [63:0]             req_value_bits,
   input  wire                    req_is_signed,
   input  wire [4:0]              req_radix,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [6:0]             rsp_out_char,
   output logic                   rsp_negative,
   output logic                   rsp_last,
   output logic [6:0]             rsp_digit_count
);

   localparam int CB     = itr_pkg::CHUNK_BITS;
   localparam int PW     = ((VALUE_WIDTH + CB - 1) / CB) * CB;
   localparam int CHUNKS = PW / CB;
   localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int MAXD   = VALUE_WIDTH;
   localparam int AW     = $clog2(MAXD);
   localparam int CNTW   = $clog2(MAXD + 1);

   // Control registers
   logic            rsp_valid_ff, rsp_valid_in;
   logic            done_ff, done_in;
   // Payload registers
   logic [PW-1:0]   mag_ff, mag_in;
   logic [3:0]      rem_ff, rem_in;
   logic            qnz_ff, qnz_in;
   logic [CW-1:0]   chunk_ff, chunk_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic            sign_ff, sign_in;
   logic [4:0]      radix_ff, radix_in;
   logic [3:0]      rd_digit_ff;
   logic [6:0]      char_ff, char_in;
   logic            neg_ff, neg_in;
   logic            last_ff, last_in;
   logic [6:0]      cnt_out_ff, cnt_out_in;

   logic [3:0]           dig_mem [MAXD];
   logic [VALUE_WIDTH-1:0] value_w;
   logic                 start;
   logic                 out_busy;
   logic [CB-1:0]        quot_byte;
   logic [3:0]           div_rem;

   assign value_w   = req_value_bits[VALUE_WIDTH-1:0];
   assign req_ready = (ctrl.act == itr_pkg::ACT_LOAD);
   assign start     = req_valid && req_ready;
   assign out_busy  = rsp_valid_ff && !rsp_ready;

   assign status.start       = start;
   assign status.chunk_more  = (chunk_ff != CW'(CHUNKS - 1));
   assign status.quot_nz     = qnz_ff;
   assign status.out_busy    = out_busy;
   assign status.digits_more = !done_ff;

   // Restoring division of the top byte, one bit per step
   always_comb begin
      logic [4:0] t;
      logic [3:0] r;
      r = rem_ff;
      quot_byte = '0;
      for (int i = CB - 1; i >= 0; i--) begin
         t = {r, mag_ff[PW - CB + i]};
         if (t >= radix_ff) begin
            t = t - radix_ff;
            quot_byte[i] = 1'b1;
         end
         r = t[3:0];
      end
      div_rem = r;
   end

   // Next-state logic driven by the control word
   always_comb begin
      logic [VALUE_WIDTH-1:0] magn;
      logic                   neg;
      logic [4:0]             r;
      neg  = req_is_signed && value_w[VALUE_WIDTH-1];
      magn = neg ? VALUE_WIDTH'(~value_w + VALUE_WIDTH'(1)) : value_w;
      r    = req_radix;
      if (r < itr_pkg::RADIX_MIN) begin
         r = itr_pkg::RADIX_MIN;
      end else if (r > itr_pkg::RADIX_MAX) begin
         r = itr_pkg::RADIX_MAX;
      end

      mag_in       = mag_ff;
      rem_in       = rem_ff;
      qnz_in       = qnz_ff;
      chunk_in     = chunk_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      sign_in      = sign_ff;
      radix_in     = radix_ff;
      done_in      = done_ff;
      char_in      = char_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      cnt_out_in   = cnt_out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (ctrl.act)
         itr_pkg::ACT_LOAD: begin
            if (start) begin
               mag_in   = PW'(magn);
               rem_in   = '0;
               qnz_in   = 1'b0;
               chunk_in = '0;
               count_in = '0;
               sign_in  = neg;
               radix_in = r;
            end
         end
         itr_pkg::ACT_DIV: begin
            mag_in   = PW'({mag_ff, quot_byte});
            rem_in   = div_rem;
            qnz_in   = qnz_ff || (quot_byte != '0);
            chunk_in = chunk_ff + CW'(1);
         end
         itr_pkg::ACT_STORE: begin
            // Remainder is the next digit; quotient stays in mag
            count_in = count_ff + CNTW'(1);
            idx_in   = count_ff[AW-1:0];
            rem_in   = '0;
            qnz_in   = 1'b0;
            chunk_in = '0;
            done_in  = 1'b0;
         end
         itr_pkg::ACT_PUSH: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               char_in      = itr_pkg::digit_to_ascii(rd_digit_ff);
               neg_in       = sign_ff;
               last_in      = (idx_ff == '0);
               cnt_out_in   = (idx_ff == '0) ? 7'(count_ff) : 7'd0;
               done_in      = (idx_ff == '0);
               idx_in       = idx_ff - AW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      rem_ff     <= rem_in;
      qnz_ff     <= qnz_in;
      chunk_ff   <= chunk_in;
      count_ff   <= count_in;
      idx_ff     <= idx_in;
      sign_ff    <= sign_in;
      radix_ff   <= radix_in;
      char_ff    <= char_in;
      neg_ff     <= neg_in;
      last_ff    <= last_in;
      cnt_out_ff <= cnt_out_in;
   end

   // Digit store, least significant digit at address zero
   always_ff @(posedge clock) begin
      if (ctrl.act == itr_pkg::ACT_STORE) begin
         dig_mem[count_ff[AW-1:0]] <= rem_ff;
      end
      rd_digit_ff <= dig_mem[idx_ff];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_negative    = neg_ff;
   assign rsp_last        = last_ff;
   assign rsp_digit_count = cnt_out_ff;

endmodule

`default_nettype wire

// ===== design/integer_to_radix_text.sv =====
// Top level of the integer to radix text converter.
// Depends on itr_pkg, itr_sequencer, itr_datapath and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Converts the low VALUE_WIDTH bits of req_value_bits (two's complement when
// req_is_signed is set) to upper-case ASCII digits in req_radix (saturated to
// 2..16), most significant first, no leading zeros; zero gives a single '0'.
// One rsp transaction per digit; rsp_negative is set on every digit of a
// negative value, rsp_last marks the final digit, which also carries the
// digit count. A small microprogram drives the datapath: each digit comes from
// byte-wise division by the radix over CHUNKS bytes (CHUNKS = VALUE_WIDTH/8
// rounded up, 8 at the default width). A new transaction is accepted only
// once the previous one has handed its last digit to the output register.
module integer_to_radix_text #(
   parameter int VALUE_WIDTH = itr_pkg::VALUE_WIDTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [63:0] req_value_bits,
   input  wire         req_is_signed,
   input  wire  [4:0]  req_radix,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [6:0]  rsp_out_char,
   output logic        rsp_negative,
   output logic        rsp_last,
   output logic [6:0]  rsp_digit_count
);

   itr_pkg::ctrl_word_type ctrl;
   itr_pkg::status_type    status;
   logic                   char_ok;
   logic                   rsp_stall;

   itr_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   itr_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value_bits  (req_value_bits),
      .req_is_signed   (req_is_signed),
      .req_radix       (req_radix),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_negative    (rsp_negative),
      .rsp_last        (rsp_last),
      .rsp_digit_count (rsp_digit_count)
   );

   // Digit alphabet and output stall for the checks below
   assign char_ok   = ((rsp_out_char >= itr_pkg::ASCII_ZERO) &&
                       (rsp_out_char <= itr_pkg::ASCII_NINE)) ||
                      ((rsp_out_char >= itr_pkg::ASCII_UPPER_A) &&
                       (rsp_out_char <= itr_pkg::ASCII_UPPER_F));
   assign rsp_stall = rsp_valid && !rsp_ready;

   // Busy right after accepting a transaction
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // Held digit stays put until taken
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_out_char))
   // Count only on the final digit
   `ASSERT_IMPLIES(a_count_on_last, clock, reset, rsp_valid && !rsp_last, rsp_digit_count == 7'd0)
   // Final digit always reports a nonzero count
   `ASSERT_IMPLIES(a_count_nonzero, clock, reset, rsp_valid && rsp_last, rsp_digit_count != 7'd0)
   // Characters stay within the digit alphabet
   `ASSERT_IMPLIES(a_char_range, clock, reset, rsp_valid, char_ok)

endmodule

`default_nettype wire

// ===== tb/integer_to_radix_text_test.sv =====
// Self-checking testbench for integer_to_radix_text: predicts digit strings and
// checks every rsp transaction. Depends on itr_pkg and the integer_to_radix_text RTL.
`timescale 1ns / 100ps

// Holds the digits still owed by the block and checks each one as it arrives.
class radix_text_checker;
   typedef struct {
      logic [6:0] out_char;
      logic       negative;
      logic       last;
      logic [6:0] digit_count;
   } radix_digit_type;

   int value_bits;
   radix_digit_type owed_digits[$];
   int failures;
   int conversions_noted;
   int digits_checked;

   function new(int width);
      value_bits = width;
      failures = 0;
      conversions_noted = 0;
      digits_checked = 0;
   endfunction

   // Convert one accepted transaction and queue its digits, MSB first.
   function void note_conversion(logic [63:0] value, logic is_signed, logic [4:0] radix);
      logic [63:0] mask;
      logic [63:0] magnitude;
      logic [63:0] base;
      logic [3:0]  lsd_first[64];
      logic        neg;
      int          count;
      radix_digit_type d;
      mask = (value_bits >= 64) ? '1 : ((64'd1 << value_bits) - 64'd1);
      base = (radix < itr_pkg::RADIX_MIN) ? 64'(itr_pkg::RADIX_MIN) :
             (radix > itr_pkg::RADIX_MAX) ? 64'(itr_pkg::RADIX_MAX) : 64'(radix);
      magnitude = value & mask;
      neg = is_signed && magnitude[value_bits-1];
      // unsigned negate, so the most negative value comes out right
      if (neg) magnitude = (~magnitude + 64'd1) & mask;
      count = 0;
      do begin
         lsd_first[count] = 4'(magnitude % base);
         magnitude = magnitude / base;
         count++;
      end while (magnitude != 0 && count < 64);
      for (int k = count - 1; k >= 0; k--) begin
         d.out_char = (lsd_first[k] < itr_pkg::DIGIT_TEN) ?
                      itr_pkg::ASCII_ZERO + 7'(lsd_first[k]) :
                      itr_pkg::ASCII_UPPER_A + 7'(lsd_first[k] - itr_pkg::DIGIT_TEN);
         d.negative = neg;
         d.last = (k == 0);
         d.digit_count = (k == 0) ? 7'(count) : 7'd0;
         owed_digits.push_back(d);
      end
      conversions_noted++;
   endfunction

   // Compare one rsp transaction against the oldest owed digit.
   function void check_digit(logic [6:0] out_char, logic negative, logic last,
                             logic [6:0] digit_count);
      radix_digit_type d;
      digits_checked++;
      if (owed_digits.size() == 0) begin
         $error("unexpected digit 0x%0h with no conversion pending", out_char);
         failures++;
         return;
      end
      d = owed_digits.pop_front();
      if (out_char !== d.out_char) begin
         $error("out_char: expected 0x%0h actual 0x%0h", d.out_char, out_char);
         failures++;
      end
      if (negative !== d.negative) begin
         $error("negative: expected %0b actual %0b", d.negative, negative);
         failures++;
      end
      if (last !== d.last) begin
         $error("last: expected %0b actual %0b", d.last, last);
         failures++;
      end
      if (digit_count !== d.digit_count) begin
         $error("digit_count: expected %0d actual %0d", d.digit_count, digit_count);
         failures++;
      end
   endfunction

   function int owed_count();
      return owed_digits.size();
   endfunction
endclass

module integer_to_radix_text_test;
   localparam int VALUE_BITS   = itr_pkg::VALUE_WIDTH_DEF;
   localparam int RANDOM_ITEMS = 97;
   localparam int IDLE_LIMIT   = 5000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 1000;

   typedef enum {RX_STREAM, RX_COIN, RX_PERIODIC} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_value_bits = '0;
   logic        req_is_signed = 1'b0;
   logic [4:0]  req_radix = itr_pkg::RADIX_MIN;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [6:0]  rsp_out_char;
   logic        rsp_negative;
   logic        rsp_last;
   logic [6:0]  rsp_digit_count;

   radix_text_checker checker_h;
   int burst_left = 0;

   integer_to_radix_text #(.VALUE_WIDTH(VALUE_BITS)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value_bits  (req_value_bits),
      .req_is_signed   (req_is_signed),
      .req_radix       (req_radix),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_negative    (rsp_negative),
      .rsp_last        (rsp_last),
      .rsp_digit_count (rsp_digit_count)
   );

   always #10 clock = ~clock;

   // Offer one conversion; sender runs in bursts, usually with idle gaps between them.
   task automatic offer_conversion(logic [63:0] value, logic is_signed, logic [4:0] radix);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_value_bits <= value;
      req_is_signed  <= is_signed;
      req_radix      <= radix;
      do @(posedge clock); while (!req_ready);
      checker_h.note_conversion(value, is_signed, radix);
   endtask

   function automatic logic [63:0] random_operand();
      logic [63:0] v;
      int unsigned width;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2: v = 64'($urandom_range(0, 999));
         3, 4, 5: begin
            width = $urandom_range(1, 64);
            v = v >> (64 - width);
         end
         6, 7: ;
         8: begin
            case ($urandom_range(0, 3))
               0: v = '1;
               1: v = 64'h8000_0000_0000_0000;
               2: v = 64'h7FFF_FFFF_FFFF_FFFF;
               default: v = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
            endcase
         end
         default: v = -64'($urandom_range(1, 5000));
      endcase
      return v;
   endfunction

   // Receiver: changing stall patterns plus one long hold-off during the random phase.
   rx_mode_type rx_mode = RX_STREAM;
   int rx_left = 0;
   int rx_phase = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && checker_h != null && checker_h.conversions_noted >= 40) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            rx_left = $urandom_range(5, 80);
         end
         rx_left--;
         rx_phase++;
         case (rx_mode)
            RX_STREAM:   rsp_ready <= 1'b1;
            RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
            default:     rsp_ready <= (rx_phase % 3 == 0);
         endcase
      end
   end

   // Check every digit transaction at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         checker_h.check_digit(rsp_out_char, rsp_negative, rsp_last, rsp_digit_count);
   end

   // Watchdog: end the run when nothing moves for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [4:0] radix;
      checker_h = new(VALUE_BITS);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero, extremes, most negative, hex letters, radix saturation
      offer_conversion(64'd0, 1'b0, 5'd10);
      offer_conversion(64'd0, 1'b1, 5'd2);
      offer_conversion('1, 1'b0, 5'd2);
      offer_conversion('1, 1'b0, 5'd16);
      offer_conversion('1, 1'b1, 5'd10);
      offer_conversion('1, 1'b0, 5'd10);
      offer_conversion(64'h8000_0000_0000_0000, 1'b1, 5'd2);
      offer_conversion(64'h8000_0000_0000_0000, 1'b1, 5'd10);
      offer_conversion(64'h8000_0000_0000_0000, 1'b0, 5'd16);
      offer_conversion(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 5'd10);
      offer_conversion(64'h0123_4567_89AB_CDEF, 1'b0, 5'd16);
      offer_conversion(64'hFEDC_BA98_7654_3210, 1'b1, 5'd16);
      offer_conversion(64'd255, 1'b0, 5'd0);
      offer_conversion(64'd255, 1'b0, 5'd1);
      offer_conversion(64'd255, 1'b0, 5'd17);
      offer_conversion(64'd255, 1'b0, 5'd31);
      offer_conversion(64'd26, 1'b0, 5'd3);
      offer_conversion(64'd14, 1'b0, 5'd15);
      offer_conversion(64'd15, 1'b0, 5'd16);
      offer_conversion(64'd9, 1'b0, 5'd10);
      offer_conversion(64'd10, 1'b0, 5'd10);
      offer_conversion(-64'd1000, 1'b1, 5'd8);
      offer_conversion(64'd1, 1'b0, 5'd7);

      // Random: mostly legal radices, some out of range
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 9) < 8)
            radix = 5'($urandom_range(2, 16));
         else
            radix = 5'($urandom_range(0, 31));
         offer_conversion(random_operand(), 1'($urandom_range(0, 1)), radix);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (checker_h.owed_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d conversions and %0d digit transactions,",
               checker_h.conversions_noted, checker_h.digits_checked);
      $display("signed and unsigned, radix 0..31 with saturation, zero and extreme values");
      if (checker_h.failures == 0 && checker_h.owed_count() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
